// ===== sv/spdfr_pkg.sv =====
// Shared types and constants for the serial packet deframer.
// Used by spdfr_core and serial_packet_deframer; depends on nothing.
`default_nettype none

package spdfr_pkg;

   // Framing bytes
   localparam logic [7:0] TXT_START = 8'h40;  // '@'
   localparam logic [7:0] TXT_CR    = 8'h0D;
   localparam logic [7:0] TXT_LF    = 8'h0A;
   localparam logic [7:0] BIN_START = 8'hFF;
   localparam logic [7:0] BIN_TAIL  = 8'hFE;

   // Sticky error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_TAIL     = 2'd2;

   // Receive modes
   localparam logic MODE_TEXT   = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // Configuration register indexes
   localparam logic CSR_RX_MODE   = 1'b0;
   localparam logic CSR_RX_ENABLE = 1'b1;

   localparam int COUNT_W = 7;

   // One result beat
   typedef struct packed {
      logic               data_valid;
      logic [7:0]         data_byte;
      logic [5:0]         data_index;
      logic               frame_done;
      logic [COUNT_W-1:0] frame_length;
      logic [1:0]         error_code;
      logic               area_full;
      logic               full_warning;
   } result_type;

   // Framing state as seen from outside the core
   typedef struct packed {
      logic [1:0]         phase;
      logic [COUNT_W-1:0] count;
      logic               full;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/spdfr_core.sv =====
// Framing state machine and per-byte decode for the serial packet deframer.
// Depends on spdfr_pkg.
`default_nettype none

module spdfr_core #(
   parameter int TEXT_CAPACITY = 32,
   parameter int BIN_LEN       = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,      // one byte is processed this cycle
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   rx_mode,
   input  wire logic                   rx_enable,
   output spdfr_pkg::result_type       result,
   output spdfr_pkg::status_type       status
);
   import spdfr_pkg::*;

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_END  = 2'd2;

   localparam logic [COUNT_W-1:0] TEXT_LIMIT = COUNT_W'(TEXT_CAPACITY - 3);
   localparam logic [COUNT_W-1:0] BIN_LIMIT  = COUNT_W'(BIN_LEN);

   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               full_ff, full_in;
   logic [1:0]         error_ff, error_in;

   // Next state and result for the byte on rx_byte
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      full_in  = full_ff;
      error_in = error_ff;
      result   = '0;

      if (rx_enable) begin
         if (full_ff) begin
            result.full_warning = 1'b1;
            error_in            = ERR_OVERFLOW;
         end else if (rx_mode == MODE_TEXT) begin
            case (phase_ff)
               PH_WAIT: begin
                  if (rx_byte == TXT_START) phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (rx_byte == TXT_CR) begin
                     phase_in = PH_END;
                  end else if (count_ff < TEXT_LIMIT) begin
                     result.data_valid = 1'b1;
                     result.data_byte  = rx_byte;
                     result.data_index = count_ff[5:0];
                     count_in          = count_ff + 1'b1;
                  end else begin
                     // cut the packet and lock the area
                     result.frame_done   = 1'b1;
                     result.frame_length = count_ff;
                     phase_in            = PH_WAIT;
                     count_in            = '0;
                     full_in             = 1'b1;
                     error_in            = ERR_OVERFLOW;
                  end
               end
               default: begin
                  if (rx_byte == TXT_LF) begin
                     result.frame_done   = 1'b1;
                     result.frame_length = count_ff;
                     phase_in            = PH_WAIT;
                     count_in            = '0;
                  end
               end
            endcase
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  if (rx_byte == BIN_START) phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (count_ff < BIN_LIMIT) begin
                     result.data_valid = 1'b1;
                     result.data_byte  = rx_byte;
                     result.data_index = count_ff[5:0];
                     count_in          = count_ff + 1'b1;
                  end else if (rx_byte == BIN_TAIL) begin
                     result.frame_done   = 1'b1;
                     result.frame_length = count_ff;
                     phase_in            = PH_WAIT;
                     count_in            = '0;
                  end else begin
                     // wrong tail: flag it and keep waiting
                     error_in = ERR_TAIL;
                  end
               end
               default: begin
                  // ending phase carried over from text mode: ignore
               end
            endcase
         end
      end

      result.error_code = error_in;
      result.area_full  = full_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         full_ff  <= 1'b0;
         error_ff <= ERR_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         full_ff  <= full_in;
         error_ff <= error_in;
      end
   end

   assign status.phase = phase_ff;
   assign status.count = count_ff;
   assign status.full  = full_ff;

endmodule

`default_nettype wire

// ===== sv/serial_packet_deframer.sv =====
// Top level of the serial packet deframer: stream ports, input and result registers.
// Depends on spdfr_pkg and spdfr_core.
`default_nettype none

// Takes one received byte per beat on req_ and gives exactly one result beat on
// rsp_ for each. A byte is held in an input register, decoded against the
// framing state and written to the result register, and a new byte can be taken
// every cycle; throughput is one byte per clock, paced only by rsp_tready.
// rsp_tuser marks a stored payload byte and rsp_tlast marks the end of a packet
// (correct end or overflow cut). Configuration is written through csr_ with no
// handshake and should only be changed while no byte is in flight.
module serial_packet_deframer #(
   parameter int TEXT_CAPACITY = 32,  // 4..64, text payload limit is this minus 3
   parameter int BIN_LEN       = 4    // 1..64 binary payload bytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Byte input
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Result output
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,    // [7:0] data_byte, [13:8] data_index,
                                          // [20:14] frame_length, [22:21] error_code,
                                          // [23] area_full, [24] full_warning, rest 0
   output      logic        rsp_tlast,    // frame_done
   output      logic        rsp_tuser,    // data_valid
   // Configuration
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic        csr_wdata
);
   import spdfr_pkg::*;

   logic       mode_ff, enable_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type core_result;
   status_type core_status;
   logic       advance;
   logic       step;

   // Result slot is free or being emptied this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         enable_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RX_MODE:   mode_ff   <= csr_wdata;
            CSR_RX_ENABLE: enable_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   spdfr_core #(
      .TEXT_CAPACITY (TEXT_CAPACITY),
      .BIN_LEN       (BIN_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .rx_mode   (mode_ff),
      .rx_enable (enable_ff),
      .result    (core_result),
      .status    (core_status)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.data_valid;
   assign rsp_tlast  = out_ff.frame_done;
   assign rsp_tdata  = {7'd0, out_ff.full_warning, out_ff.area_full, out_ff.error_code,
                        out_ff.frame_length, out_ff.data_index, out_ff.data_byte};

   // Checks
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      core_status.full |=> core_status.full)
      else $error("full flag cleared without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      core_status.count <= COUNT_W'(64))
      else $error("byte count beyond packet limit");

   a_store_xor_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tlast))
      else $error("payload byte and frame end in one result");

   a_warn_implies_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.full_warning) |->
         (out_ff.area_full && out_ff.error_code == ERR_OVERFLOW))
      else $error("full warning without full area and overflow error");

   a_step_fills_slot: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("processed byte produced no result");

endmodule

`default_nettype wire
